/* rtl/core/m3i_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse core.
// Used by every module in rtl/core; depends on nothing else.
package m3i_pkg;

   localparam int Lanes = 9;
   localparam int DivSteps = 32;

   // Rows and columns that form each cofactor: entry (i, j) of the adjugate
   // uses rows RowA[j], RowB[j] and columns ColA[i], ColB[i].
   localparam int RowA [3] = '{1, 0, 0};
   localparam int RowB [3] = '{2, 2, 1};
   localparam int ColA [3] = '{2, 0, 1};
   localparam int ColB [3] = '{1, 2, 0};

   localparam logic [63:0] DetPosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DetNegLimit = 64'h8000_0000_0000_0000;
   localparam logic [32:0] InvPosLimit = 33'h0_7FFF_FFFF;
   localparam logic [32:0] InvNegLimit = 33'h0_8000_0000;
   localparam logic [97:0] RoundHalf = 98'h8000;

   typedef logic [2:0][2:0][31:0] mat_type;

   typedef struct packed {
      logic [Lanes-1:0][63:0] adj;
      logic [2:0][31:0]       row0;
   } cof_type;

   typedef struct packed {
      logic [Lanes-1:0][63:0] adj;
      logic [63:0]            dmag;
      logic                   dneg;
      logic [63:0]            det;
      logic                   det_sat;
   } det_type;

   typedef struct packed {
      logic [Lanes-1:0][31:0] inv;
      logic [63:0]            det;
      logic                   singular;
      logic                   saturated;
   } rsp_type;

endpackage

/* rtl/core/m3i_cofactor.sv */
// Adjugate stage pair: cofactor products, then signed differences.
// Depends on m3i_pkg.
module m3i_cofactor (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  m3i_pkg::mat_type  in_mat,
   output logic              out_valid,
   input  logic              out_ready,
   output m3i_pkg::cof_type  out_data
);

   localparam int Stages = 2;

   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages:0]   adv;

   logic [m3i_pkg::Lanes-1:0][63:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [2:0][31:0]                row0_ff, row0_in;
   m3i_pkg::cof_type                data_ff, data_in;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      valid_in[1] = adv[1] ? valid_ff[0] : valid_ff[1];
   end

   always_comb begin
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      row0_in = row0_ff;
      data_in = data_ff;
      if (adv[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pa_in[i*3+j] = $signed(in_mat[m3i_pkg::RowA[j]][m3i_pkg::ColB[i]])
                            * $signed(in_mat[m3i_pkg::RowB[j]][m3i_pkg::ColA[i]]);
               pb_in[i*3+j] = $signed(in_mat[m3i_pkg::RowA[j]][m3i_pkg::ColA[i]])
                            * $signed(in_mat[m3i_pkg::RowB[j]][m3i_pkg::ColB[i]]);
            end
         end
         row0_in = in_mat[0];
      end
      if (adv[1]) begin
         // The true difference always fits in 64 bits, so wrapping is exact.
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (j == 1) begin
                  data_in.adj[i*3+j] = pb_ff[i*3+j] - pa_ff[i*3+j];
               end else begin
                  data_in.adj[i*3+j] = pa_ff[i*3+j] - pb_ff[i*3+j];
               end
            end
         end
         data_in.row0 = row0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      row0_ff <= row0_in;
      data_ff <= data_in;
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = data_ff;

endmodule

/* rtl/core/m3i_det.sv */
// Determinant pipeline: first-row expansion in Q48.48, then rounding to
// Q32.32 with saturation. Depends on m3i_pkg.
module m3i_det (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  m3i_pkg::cof_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output m3i_pkg::det_type  out_data
);

   localparam int Stages = 6;

   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages:0]   adv;

   logic [m3i_pkg::Lanes-1:0][63:0] adj_ff [Stages-1];
   logic [m3i_pkg::Lanes-1:0][63:0] adj_in [Stages-1];
   logic [2:0][63:0] pph_ff, pph_in;
   logic [2:0][64:0] ppl_ff, ppl_in;
   logic [2:0][95:0] prod_ff, prod_in;
   logic [97:0]      acc_ff, acc_in;
   logic [97:0]      mag_ff, mag_in;
   logic             mneg_ff, mneg_in;
   logic [81:0]      rnd_ff, rnd_in;
   logic             rneg_ff, rneg_in;
   m3i_pkg::det_type data_ff, data_in;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      logic [97:0] rsum;
      logic [63:0] lim;
      logic        over;
      logic [63:0] dmag;

      rsum = '0;
      lim  = '0;
      over = 1'b0;
      dmag = '0;

      for (int k = 0; k < Stages - 1; k++) begin
         adj_in[k] = adj_ff[k];
      end
      pph_in  = pph_ff;
      ppl_in  = ppl_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      mag_in  = mag_ff;
      mneg_in = mneg_ff;
      rnd_in  = rnd_ff;
      rneg_in = rneg_ff;
      data_in = data_ff;

      // Each 64x32 product is split at bit 32 of the cofactor.
      if (adv[0]) begin
         adj_in[0] = in_data.adj;
         for (int i = 0; i < 3; i++) begin
            pph_in[i] = $signed(in_data.adj[i*3][63:32]) * $signed(in_data.row0[i]);
            ppl_in[i] = $signed({1'b0, in_data.adj[i*3][31:0]}) * $signed(in_data.row0[i]);
         end
      end
      if (adv[1]) begin
         adj_in[1] = adj_ff[0];
         for (int i = 0; i < 3; i++) begin
            prod_in[i] = {pph_ff[i], 32'h0} + {{31{ppl_ff[i][64]}}, ppl_ff[i]};
         end
      end
      if (adv[2]) begin
         adj_in[2] = adj_ff[1];
         acc_in = {{2{prod_ff[0][95]}}, prod_ff[0]} + {{2{prod_ff[1][95]}}, prod_ff[1]}
                + {{2{prod_ff[2][95]}}, prod_ff[2]};
      end
      if (adv[3]) begin
         adj_in[3] = adj_ff[2];
         mneg_in   = acc_ff[97];
         mag_in    = acc_ff[97] ? 98'd0 - acc_ff : acc_ff;
      end
      if (adv[4]) begin
         adj_in[4] = adj_ff[3];
         rneg_in   = mneg_ff;
         rsum      = mag_ff + m3i_pkg::RoundHalf;
         rnd_in    = rsum[97:16];
      end
      if (adv[5]) begin
         lim  = rneg_ff ? m3i_pkg::DetNegLimit : m3i_pkg::DetPosLimit;
         over = (rnd_ff[81:64] != '0) || (rnd_ff[63:0] > lim);
         dmag = over ? lim : rnd_ff[63:0];
         data_in.adj     = adj_ff[4];
         data_in.dmag    = dmag;
         data_in.dneg    = rneg_ff;
         data_in.det     = rneg_ff ? 64'd0 - dmag : dmag;
         data_in.det_sat = over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int k = 0; k < Stages - 1; k++) begin
         adj_ff[k] <= adj_in[k];
      end
      pph_ff  <= pph_in;
      ppl_ff  <= ppl_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      mneg_ff <= mneg_in;
      rnd_ff  <= rnd_in;
      rneg_ff <= rneg_in;
      data_ff <= data_in;
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = data_ff;

endmodule

/* rtl/core/m3i_divider.sv */
// Nine-lane pipelined restoring divider: adjugate over determinant, one
// quotient bit per stage, then rounding and clamping. Depends on m3i_pkg.
module m3i_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  m3i_pkg::det_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output m3i_pkg::rsp_type  out_data
);

   localparam int Stages = m3i_pkg::DivSteps + 4;
   localparam int LaneStages = Stages - 1;
   localparam int LastStep = m3i_pkg::DivSteps + 1;

   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic        neg;
      logic        ovf;
      logic        rnd;
   } lane_type;

   typedef struct packed {
      logic [63:0] dmag;
      logic [63:0] det;
      logic        det_sat;
   } com_type;

   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages:0]   adv;

   lane_type [m3i_pkg::Lanes-1:0] lane_ff [LaneStages];
   lane_type [m3i_pkg::Lanes-1:0] lane_in [LaneStages];
   com_type  com_ff [LaneStages];
   com_type  com_in [LaneStages];
   m3i_pkg::rsp_type data_ff, data_in;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   // Common fields ride along with the lanes.
   always_comb begin
      com_in[0] = com_ff[0];
      if (adv[0]) begin
         com_in[0].dmag    = in_data.dmag;
         com_in[0].det     = in_data.det;
         com_in[0].det_sat = in_data.det_sat;
      end
      for (int s = 1; s < LaneStages; s++) begin
         com_in[s] = adv[s] ? com_ff[s-1] : com_ff[s];
      end
   end

   always_comb begin
      lane_type    nxt;
      logic [63:0] t;

      nxt = '0;
      t   = '0;

      // Magnitude and result sign.
      for (int l = 0; l < m3i_pkg::Lanes; l++) begin
         nxt     = '0;
         nxt.rem = in_data.adj[l][63] ? 64'd0 - in_data.adj[l] : in_data.adj[l];
         nxt.neg = in_data.adj[l][63] ^ in_data.dneg;
         lane_in[0][l] = adv[0] ? nxt : lane_ff[0][l];
      end

      // The numerator is the magnitude shifted up by 16. Its top 48 bits seed
      // the remainder; if they already reach the divisor, the quotient cannot
      // fit in 32 bits.
      for (int l = 0; l < m3i_pkg::Lanes; l++) begin
         nxt     = lane_ff[0][l];
         nxt.rem = {16'h0, lane_ff[0][l].rem[63:16]};
         nxt.low = {lane_ff[0][l].rem[15:0], 16'h0};
         nxt.quo = '0;
         nxt.ovf = {16'h0, lane_ff[0][l].rem[63:16]} >= com_ff[0].dmag;
         lane_in[1][l] = adv[1] ? nxt : lane_ff[1][l];
      end

      for (int s = 2; s <= LastStep; s++) begin
         for (int l = 0; l < m3i_pkg::Lanes; l++) begin
            nxt = lane_ff[s-1][l];
            t   = {nxt.rem[62:0], nxt.low[31]};
            if (t >= com_ff[s-1].dmag) begin
               nxt.rem = t - com_ff[s-1].dmag;
               nxt.quo = {nxt.quo[30:0], 1'b1};
            end else begin
               nxt.rem = t;
               nxt.quo = {nxt.quo[30:0], 1'b0};
            end
            nxt.low = {nxt.low[30:0], 1'b0};
            lane_in[s][l] = adv[s] ? nxt : lane_ff[s][l];
         end
      end

      // Round half away from zero: bump when twice the remainder reaches d.
      for (int l = 0; l < m3i_pkg::Lanes; l++) begin
         nxt     = lane_ff[LastStep][l];
         nxt.rnd = nxt.rem >= (com_ff[LastStep].dmag - nxt.rem);
         lane_in[LaneStages-1][l] = adv[LaneStages-1] ? nxt : lane_ff[LaneStages-1][l];
      end
   end

   always_comb begin
      logic [32:0] qr;
      logic [32:0] lim;
      logic [32:0] qm;
      logic [32:0] val;
      logic        over;
      logic        any_over;
      logic        sing;

      qr       = '0;
      lim      = '0;
      qm       = '0;
      val      = '0;
      over     = 1'b0;
      any_over = 1'b0;
      sing     = com_ff[LaneStages-1].dmag == '0;
      data_in  = data_ff;
      if (adv[Stages-1]) begin
         for (int l = 0; l < m3i_pkg::Lanes; l++) begin
            qr   = {1'b0, lane_ff[LaneStages-1][l].quo}
                 + {32'h0, lane_ff[LaneStages-1][l].rnd};
            lim  = lane_ff[LaneStages-1][l].neg ? m3i_pkg::InvNegLimit
                                                : m3i_pkg::InvPosLimit;
            over = lane_ff[LaneStages-1][l].ovf || (qr > lim);
            qm   = over ? lim : qr;
            val  = lane_ff[LaneStages-1][l].neg ? 33'd0 - qm : qm;
            data_in.inv[l] = sing ? 32'h0 : val[31:0];
            any_over = any_over || over;
         end
         data_in.det       = com_ff[LaneStages-1].det;
         data_in.singular  = sing;
         data_in.saturated = com_ff[LaneStages-1].det_sat || (!sing && any_over);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int s = 0; s < LaneStages; s++) begin
         lane_ff[s] <= lane_in[s];
         com_ff[s]  <= com_in[s];
      end
      data_ff <= data_in;
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = data_ff;

endmodule

/* rtl/core/matrix3_inverse_with_determinant_core.sv */
// 3x3 matrix inverse with determinant, Q16.16 in, Q16.16 and Q32.32 out.
// The pipeline is made of 2 adjugate
// stages, 6 determinant stages and 36 divider stages (32 of them one quotient bit each).
// Throughput is one word per cycle while the output is not stalled; bubbles close up under output stalls.
// Reset is synchronous and clears only the stage valid bits.
module matrix3_inverse_with_determinant_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_m00,
   input  logic [31:0] req_m01,
   input  logic [31:0] req_m02,
   input  logic [31:0] req_m10,
   input  logic [31:0] req_m11,
   input  logic [31:0] req_m12,
   input  logic [31:0] req_m20,
   input  logic [31:0] req_m21,
   input  logic [31:0] req_m22,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_inv00,
   output logic [31:0] rsp_inv01,
   output logic [31:0] rsp_inv02,
   output logic [31:0] rsp_inv10,
   output logic [31:0] rsp_inv11,
   output logic [31:0] rsp_inv12,
   output logic [31:0] rsp_inv20,
   output logic [31:0] rsp_inv21,
   output logic [31:0] rsp_inv22,
   output logic [63:0] rsp_determinant,
   output logic        rsp_singular,
   output logic        rsp_saturated
);

   m3i_pkg::mat_type mat;
   m3i_pkg::cof_type cof_data;
   m3i_pkg::det_type det_data;
   m3i_pkg::rsp_type rsp_data;
   logic cof_valid, cof_ready, det_valid, det_ready;

   assign mat[0] = {req_m02, req_m01, req_m00};
   assign mat[1] = {req_m12, req_m11, req_m10};
   assign mat[2] = {req_m22, req_m21, req_m20};

   m3i_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_mat    (mat),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_data  (cof_data)
   );

   m3i_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_data   (cof_data),
      .out_valid (det_valid),
      .out_ready (det_ready),
      .out_data  (det_data)
   );

   m3i_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_valid),
      .in_ready  (det_ready),
      .in_data   (det_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_inv00       = rsp_data.inv[0];
   assign rsp_inv01       = rsp_data.inv[1];
   assign rsp_inv02       = rsp_data.inv[2];
   assign rsp_inv10       = rsp_data.inv[3];
   assign rsp_inv11       = rsp_data.inv[4];
   assign rsp_inv12       = rsp_data.inv[5];
   assign rsp_inv20       = rsp_data.inv[6];
   assign rsp_inv21       = rsp_data.inv[7];
   assign rsp_inv22       = rsp_data.inv[8];
   assign rsp_determinant = rsp_data.det;
   assign rsp_singular    = rsp_data.singular;
   assign rsp_saturated   = rsp_data.saturated;

   // The singular flag must agree with the determinant carried alongside.
   a_singular_det : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_singular == (rsp_determinant == 64'h0)))
      else $error("singular flag disagrees with determinant");

   // A singular word carries an all-zero inverse.
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> (rsp_inv00 == 32'h0) && (rsp_inv01 == 32'h0)
         && (rsp_inv02 == 32'h0) && (rsp_inv10 == 32'h0) && (rsp_inv11 == 32'h0)
         && (rsp_inv12 == 32'h0) && (rsp_inv20 == 32'h0) && (rsp_inv21 == 32'h0)
         && (rsp_inv22 == 32'h0))
      else $error("singular word with nonzero inverse");

   // A zero determinant can never have been clamped.
   a_singular_nosat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated)
      else $error("singular word flagged as saturated");

endmodule
